/* src/spa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spa_pkg
// shared types, widths and codes for the step pulse accumulator
// ----------------------------------------------------------------------------
package spa_pkg;

    localparam int POSITION_BITS_DEF = 64;
    localparam int UNITS_W           = 24;
    localparam int SHIFT_W           = 32;
    localparam int STEP_POS_W        = 32;
    localparam int CFG_INDEX_W       = 8;
    localparam int CFG_DATA_W        = 32;

    localparam logic [UNITS_W-1:0] UNITS_PER_STEP_RST    = 24'd1024;
    localparam logic [UNITS_W-1:0] TRIGGER_THRESHOLD_RST = 24'd512;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_UNITS_PER_STEP    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIGGER_THRESHOLD = 8'd1;

    // request codes
    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_SET_POS = 1'b1;

    typedef struct packed {
        logic [UNITS_W-1:0] units_per_step;
        logic [UNITS_W-1:0] trigger_threshold;
    } spa_cfg_t;

    typedef struct packed {
        logic step_up;
        logic step_down;
        logic status;
    } spa_result_t;

endpackage
`default_nettype wire

/* src/spa_step_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spa_step_core
// lead accumulator: tracks virtual minus commanded position and decides steps
// ----------------------------------------------------------------------------
module spa_step_core #(
    parameter int POSITION_BITS = spa_pkg::POSITION_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 advance,
    input  wire logic                                 req_type,
    input  wire logic signed [spa_pkg::SHIFT_W-1:0]   shift_amount,
    input  wire spa_pkg::spa_cfg_t                    cfg,
    output spa_pkg::spa_result_t                      result
);

    logic [POSITION_BITS-1:0] lead_reg;
    logic [POSITION_BITS-1:0] lead_next;
    logic [POSITION_BITS-1:0] shift_ext;
    logic [POSITION_BITS-1:0] lead_sum;
    logic [POSITION_BITS-1:0] units_ext;
    logic [POSITION_BITS-1:0] thr_ext;
    logic [POSITION_BITS-1:0] neg_thr;
    logic [spa_pkg::SHIFT_W-1:0] shift_mag;
    logic                     overrun;
    logic                     go_up;
    logic                     go_down;

    assign shift_ext = POSITION_BITS'(shift_amount);
    assign units_ext = POSITION_BITS'(cfg.units_per_step);
    assign thr_ext   = POSITION_BITS'(cfg.trigger_threshold);
    assign neg_thr   = '0 - thr_ext;

    // magnitude of the most negative shift still fits as unsigned
    assign shift_mag = shift_amount[spa_pkg::SHIFT_W-1]
                     ? ('0 - shift_amount) : shift_amount;
    assign overrun   = shift_mag >= spa_pkg::SHIFT_W'(cfg.units_per_step);

    assign lead_sum  = lead_reg + shift_ext;

    // positive lead: unsigned compare; negative lead: -lead > thr is lead < -thr
    assign go_up   = !lead_sum[POSITION_BITS-1] && (lead_sum > thr_ext);
    assign go_down = lead_sum[POSITION_BITS-1]
                   && ($signed(lead_sum) < $signed(neg_thr));

    always_comb
    begin
        lead_next        = lead_reg;
        result.step_up   = 1'b0;
        result.step_down = 1'b0;
        result.status    = 1'b0;
        if (req_type == spa_pkg::REQ_SET_POS)
        begin
            lead_next = '0;
        end
        else if (overrun)
        begin
            result.status = 1'b1;
        end
        else
        begin
            result.step_up   = go_up;
            result.step_down = go_down;
            if (go_up)
            begin
                lead_next = lead_sum - units_ext;
            end
            else if (go_down)
            begin
                lead_next = lead_sum + units_ext;
            end
            else
            begin
                lead_next = lead_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg <= '0;
        end
        else if (advance)
        begin
            lead_reg <= lead_next;
        end
    end

endmodule
`default_nettype wire

/* src/spa_pos_track.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spa_pos_track
// commanded position register, loaded by set-position and moved by steps
// ----------------------------------------------------------------------------
module spa_pos_track #(
    parameter int POSITION_BITS = spa_pkg::POSITION_BITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   advance,
    input  wire logic                                   req_type,
    input  wire logic signed [spa_pkg::STEP_POS_W-1:0]  step_position,
    input  wire logic [spa_pkg::UNITS_W-1:0]            units_per_step,
    input  wire spa_pkg::spa_result_t                   result
);

    localparam int PROD_W = spa_pkg::STEP_POS_W + spa_pkg::UNITS_W + 1;

    logic [POSITION_BITS-1:0] cmd_pos_reg;
    logic [POSITION_BITS-1:0] cmd_pos_next;
    logic signed [PROD_W-1:0] set_prod;
    logic [POSITION_BITS-1:0] units_ext;

    assign set_prod  = step_position * $signed({1'b0, units_per_step});
    assign units_ext = POSITION_BITS'(units_per_step);

    always_comb
    begin
        cmd_pos_next = cmd_pos_reg;
        if (req_type == spa_pkg::REQ_SET_POS)
        begin
            cmd_pos_next = POSITION_BITS'(set_prod);
        end
        else if (result.step_up)
        begin
            cmd_pos_next = cmd_pos_reg + units_ext;
        end
        else if (result.step_down)
        begin
            cmd_pos_next = cmd_pos_reg - units_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_pos_reg <= '0;
        end
        else if (advance)
        begin
            cmd_pos_reg <= cmd_pos_next;
        end
    end

endmodule
`default_nettype wire

/* src/step_pulse_accumulator_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// step_pulse_accumulator_core
// accumulator-based stepper step generator, one step pulse at most per tick
// ----------------------------------------------------------------------------
//   channel  dir  handshake            payload
//   in       in   in_valid / in_stall  req_type, shift_amount, step_position
//   out      out  out_valid / out_stall step_up, step_down, status
//   cfg      in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// one item per cycle sustained while out_stall is low; an input transfer
// passes the input register, then the result register, before result valid
// the lead accumulator add, threshold compare and step correction form the
// combinational path between the two registers
// reset clears positions and loads register defaults; cfg_ready is always high
// a stalled result holds the input stage, which stalls the input once full
// ----------------------------------------------------------------------------
module step_pulse_accumulator_core #(
    parameter int POSITION_BITS = spa_pkg::POSITION_BITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,

    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic                                   req_type,
    input  wire logic signed [spa_pkg::SHIFT_W-1:0]     shift_amount,
    input  wire logic signed [spa_pkg::STEP_POS_W-1:0]  step_position,

    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic                                        step_up,
    output logic                                        step_down,
    output logic                                        status,

    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [spa_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [spa_pkg::CFG_DATA_W-1:0]         cfg_data
);

    spa_pkg::spa_cfg_t   cfg_reg;
    spa_pkg::spa_result_t res_comb;
    spa_pkg::spa_result_t res_reg;

    logic                                  s1_valid_reg;
    logic                                  s1_req_type_reg;
    logic signed [spa_pkg::SHIFT_W-1:0]    s1_shift_reg;
    logic signed [spa_pkg::STEP_POS_W-1:0] s1_step_pos_reg;
    logic                                  out_valid_reg;
    logic                                  in_take;
    logic                                  advance;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.units_per_step    <= spa_pkg::UNITS_PER_STEP_RST;
            cfg_reg.trigger_threshold <= spa_pkg::TRIGGER_THRESHOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                spa_pkg::CFG_UNITS_PER_STEP:
                    cfg_reg.units_per_step    <= cfg_data[spa_pkg::UNITS_W-1:0];
                spa_pkg::CFG_TRIGGER_THRESHOLD:
                    cfg_reg.trigger_threshold <= cfg_data[spa_pkg::UNITS_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // stage handshake
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_req_type_reg <= req_type;
            s1_shift_reg    <= shift_amount;
            s1_step_pos_reg <= step_position;
        end
        if (advance)
        begin
            res_reg <= res_comb;
        end
    end

    spa_step_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_step_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .req_type     (s1_req_type_reg),
        .shift_amount (s1_shift_reg),
        .cfg          (cfg_reg),
        .result       (res_comb)
    );

    spa_pos_track #(
        .POSITION_BITS (POSITION_BITS)
    ) u_pos_track (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .req_type       (s1_req_type_reg),
        .step_position  (s1_step_pos_reg),
        .units_per_step (cfg_reg.units_per_step),
        .result         (res_comb)
    );

    assign out_valid = out_valid_reg;
    assign step_up   = res_reg.step_up;
    assign step_down = res_reg.step_down;
    assign status    = res_reg.status;

endmodule
`default_nettype wire
